FILE: rtl/core/assert_macros.svh
// Assertion macros shared by the RTL of the key/value table.
// Depends on a clock named clock and a synchronous reset named reset in the using module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Checked at every rising edge outside reset
`define FSKV_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
// Checked at every rising edge, reset included
`define FSKV_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);
`else
`define FSKV_ASSERT(label, prop, msg)
`define FSKV_ASSERT_ALWAYS(label, prop, msg)
`endif
`endif

FILE: rtl/core/fskv_pkg.sv
// Types, codes and string helpers of the fixed-slot key/value table.
// No dependencies.
`timescale 1ns / 1ps
package fskv_pkg;

   localparam int WORD_BITS      = 64;
   localparam int FUNC_BITS      = 2;
   localparam int CAP_BITS       = 8;
   localparam int STATUS_BITS    = 2;
   localparam int COUNT_OUT_BITS = 9;
   localparam int SLOT_IDX_BITS  = 12;   // covers up to 4096 slots
   localparam int LEN_BITS       = 4;

   // Request operations
   localparam logic [FUNC_BITS-1:0] FUNC_PUT    = 2'd0;
   localparam logic [FUNC_BITS-1:0] FUNC_GET    = 2'd1;
   localparam logic [FUNC_BITS-1:0] FUNC_DELETE = 2'd2;
   localparam logic [FUNC_BITS-1:0] FUNC_CLOSE  = 2'd3;

   // Result status codes
   localparam logic [STATUS_BITS-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_BITS-1:0] STATUS_INVALID   = 2'd1;
   localparam logic [STATUS_BITS-1:0] STATUS_OVERFLOW  = 2'd2;
   localparam logic [STATUS_BITS-1:0] STATUS_NOT_FOUND = 2'd3;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_RESP
   } state_type;

   typedef enum logic [1:0] {
      CM_NEW,
      CM_UPDATE,
      CM_CLEAR
   } commit_op_type;

   // Search token that walks down the cell row
   typedef struct packed {
      logic                     valid;
      logic                     found;
      logic [SLOT_IDX_BITS-1:0] found_idx;
      logic [WORD_BITS-1:0]     found_value;
      logic                     free;
      logic [SLOT_IDX_BITS-1:0] free_idx;
   } token_type;

   // Slot update broadcast to all cells
   typedef struct packed {
      logic                     valid;
      commit_op_type            op;
      logic [SLOT_IDX_BITS-1:0] idx;
   } commit_type;

   // Keep the low nbytes bytes and cut the string at its first NUL
   function automatic logic [WORD_BITS-1:0] norm_word(input logic [WORD_BITS-1:0] w,
                                                      input int unsigned nbytes);
      logic [WORD_BITS-1:0] r;
      logic                 live;
      r    = '0;
      live = 1'b1;
      for (int i = 0; i < 8; i++) begin
         if (live && (i < nbytes) && (w[8*i +: 8] != 8'd0)) begin
            r[8*i +: 8] = w[8*i +: 8];
         end else begin
            live = 1'b0;
         end
      end
      return r;
   endfunction

   // Bytes before the first NUL
   function automatic logic [LEN_BITS-1:0] str_len(input logic [WORD_BITS-1:0] w);
      logic [LEN_BITS-1:0] n;
      logic                live;
      n    = '0;
      live = 1'b1;
      for (int i = 0; i < 8; i++) begin
         if (live && (w[8*i +: 8] != 8'd0)) begin
            n = n + LEN_BITS'(1);
         end else begin
            live = 1'b0;
         end
      end
      return n;
   endfunction

endpackage

FILE: rtl/core/fskv_req_if.sv
// Request channel of the key/value table: valid/ready plus the request payload.
// Depends on fskv_pkg.
`timescale 1ns / 1ps
interface fskv_req_if;
   import fskv_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [FUNC_BITS-1:0] func;
   logic [WORD_BITS-1:0] key_word;
   logic [WORD_BITS-1:0] write_value;
   logic [CAP_BITS-1:0]  read_capacity;

   modport source (output valid, func, key_word, write_value, read_capacity, input ready);
   modport sink   (input valid, func, key_word, write_value, read_capacity, output ready);
endinterface

FILE: rtl/core/fskv_rsp_if.sv
// Result channel of the key/value table: valid/ready plus the result payload.
// Depends on fskv_pkg.
`timescale 1ns / 1ps
interface fskv_rsp_if;
   import fskv_pkg::*;

   logic                      valid;
   logic                      ready;
   logic [STATUS_BITS-1:0]    status;
   logic [WORD_BITS-1:0]      read_value;
   logic [COUNT_OUT_BITS-1:0] entries_in_use;

   modport source (output valid, status, read_value, entries_in_use, input ready);
   modport sink   (input valid, status, read_value, entries_in_use, output ready);
endinterface

FILE: rtl/core/fskv_cell.sv
// One slot of the key/value table: key, value, occupied mark and one token stage.
// Depends on fskv_pkg.
`timescale 1ns / 1ps
module fskv_cell #(
   parameter int KEY_BITS   = 64,
   parameter int VALUE_BITS = 64,
   parameter int CELL_INDEX = 0
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic [fskv_pkg::WORD_BITS-1:0] key_word,
   input  logic [fskv_pkg::WORD_BITS-1:0] value_word,
   input  fskv_pkg::commit_type           commit,
   input  fskv_pkg::token_type            up_token,
   output fskv_pkg::token_type            down_token
);
   import fskv_pkg::*;

   localparam logic [SLOT_IDX_BITS-1:0] MY_IDX = SLOT_IDX_BITS'(CELL_INDEX);

   logic                  used_ff, used_in;
   logic [KEY_BITS-1:0]   key_ff, key_in;
   logic [VALUE_BITS-1:0] value_ff, value_in;
   token_type             pass_ff, pass_in;
   logic                  hit;
   logic                  sel;

   // Token stage: note first key match and first free slot
   assign hit = up_token.valid && used_ff && (key_ff == key_word[KEY_BITS-1:0]);

   always_comb begin
      pass_in = up_token;
      if (hit && !up_token.found) begin
         pass_in.found       = 1'b1;
         pass_in.found_idx   = MY_IDX;
         pass_in.found_value = WORD_BITS'(value_ff);
      end
      if (up_token.valid && !used_ff && !up_token.free) begin
         pass_in.free     = 1'b1;
         pass_in.free_idx = MY_IDX;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pass_ff.valid <= 1'b0;
      end else begin
         pass_ff <= pass_in;
      end
   end

   assign down_token = pass_ff;

   // Slot update from the broadcast commit
   assign sel = commit.valid && (commit.idx == MY_IDX);

   always_comb begin
      used_in  = used_ff;
      key_in   = key_ff;
      value_in = value_ff;
      if (sel) begin
         case (commit.op)
            CM_NEW: begin
               used_in = 1'b1;
               key_in  = key_word[KEY_BITS-1:0];
            end
            CM_CLEAR: begin
               used_in = 1'b0;
            end
            default: begin
               used_in = used_ff;
            end
         endcase
         if (commit.op inside {CM_NEW, CM_UPDATE}) begin
            value_in = value_word[VALUE_BITS-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= 1'b0;
      end else begin
         used_ff <= used_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff   <= key_in;
      value_ff <= value_in;
   end

endmodule

FILE: rtl/core/fixed_slot_key_value_table.sv
// Top level of the fixed-slot key/value table: request control and the row of slot cells.
// Depends on fskv_pkg, fskv_req_if, fskv_rsp_if, fskv_cell and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"
// Usage:
//   req_ch carries one request (put, get, delete, close) per transfer; rsp_ch returns
//   exactly one result per request. Both are valid/ready channels.
//   Put, get and delete send a search token down a row of SLOT_COUNT cells, one cell
//   per cycle; the token notes the matching slot and the first free slot. When it leaves
//   the last cell the result is registered and any slot update is broadcast to the row.
//   Searching requests register their result after the launch register and every cell of
//   the row; close, any request after close, and put with an empty key skip the row.
//   One request is in flight at a time: a new request is taken only after the result of
//   the last one has been taken by the receiver.
//   A result is held on rsp_ch until the receiver takes it; req_ch.ready stays low until
//   then.
//   Reset clears all occupied marks, the entry count and the closed flag; key and value
//   storage is not cleared and is only read for occupied slots.
module fixed_slot_key_value_table #(
   parameter int SLOT_COUNT  = 256,
   parameter int KEY_BYTES   = 8,
   parameter int VALUE_BYTES = 8
) (
   input logic        clock,
   input logic        reset,
   fskv_req_if.sink   req_ch,
   fskv_rsp_if.source rsp_ch
);
   import fskv_pkg::*;

   localparam int KEY_BITS   = KEY_BYTES * 8;
   localparam int VALUE_BITS = VALUE_BYTES * 8;
   localparam int COUNT_BITS = $clog2(SLOT_COUNT + 1);

   state_type                 state_ff, state_in;
   logic [FUNC_BITS-1:0]      func_ff, func_in;
   logic [WORD_BITS-1:0]      key_ff, key_in;
   logic [WORD_BITS-1:0]      value_ff, value_in;
   logic [CAP_BITS-1:0]       cap_ff, cap_in;
   logic                      closed_ff, closed_in;
   logic [COUNT_BITS-1:0]     count_ff, count_in;
   logic                      launch_ff, launch_in;
   commit_type                commit_ff, commit_in;
   logic [STATUS_BITS-1:0]    status_ff, status_in;
   logic [WORD_BITS-1:0]      read_value_ff, read_value_in;
   logic [COUNT_OUT_BITS-1:0] entries_ff, entries_in;

   token_type                 token_chain [0:SLOT_COUNT];
   token_type                 tail;
   logic [WORD_BITS-1:0]      key_norm;
   logic                      req_xfer;
   logic                      rsp_xfer;
   logic                      shortcut;

   assign req_xfer = req_ch.valid && req_ch.ready;
   assign rsp_xfer = rsp_ch.valid && rsp_ch.ready;
   assign key_norm = norm_word(req_ch.key_word, KEY_BYTES);
   assign shortcut = closed_ff || (req_ch.func == FUNC_CLOSE) ||
                     ((req_ch.func == FUNC_PUT) && (key_norm == '0));
   assign tail     = token_chain[SLOT_COUNT];

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               state_in = shortcut ? ST_RESP : ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (tail.valid) begin
               state_in = ST_RESP;
            end
         end
         ST_RESP: begin
            if (rsp_xfer) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Handshake outputs
   always_comb begin
      req_ch.ready = (state_ff == ST_IDLE);
      rsp_ch.valid = (state_ff == ST_RESP);
   end

   assign rsp_ch.status         = status_ff;
   assign rsp_ch.read_value     = read_value_ff;
   assign rsp_ch.entries_in_use = entries_ff;

   // Request capture, result and slot update decisions
   always_comb begin
      func_in          = func_ff;
      key_in           = key_ff;
      value_in         = value_ff;
      cap_in           = cap_ff;
      closed_in        = closed_ff;
      count_in         = count_ff;
      launch_in        = 1'b0;
      commit_in        = commit_ff;
      commit_in.valid  = 1'b0;
      status_in        = status_ff;
      read_value_in    = read_value_ff;
      entries_in       = entries_ff;

      if ((state_ff == ST_IDLE) && req_xfer) begin
         func_in       = req_ch.func;
         key_in        = key_norm;
         value_in      = norm_word(req_ch.write_value, VALUE_BYTES);
         cap_in        = req_ch.read_capacity;
         read_value_in = '0;
         if (closed_ff) begin
            status_in  = STATUS_INVALID;
            entries_in = '0;
         end else if (req_ch.func == FUNC_CLOSE) begin
            closed_in  = 1'b1;
            status_in  = STATUS_OK;
            entries_in = '0;
         end else if (shortcut) begin
            // put with an empty key
            status_in  = STATUS_INVALID;
            entries_in = COUNT_OUT_BITS'(count_ff);
         end else begin
            launch_in = 1'b1;
         end
      end

      if ((state_ff == ST_SCAN) && tail.valid) begin
         read_value_in = '0;
         status_in     = STATUS_OK;
         case (func_ff)
            FUNC_PUT: begin
               if (tail.found) begin
                  commit_in = '{valid: 1'b1, op: CM_UPDATE, idx: tail.found_idx};
               end else if (tail.free) begin
                  commit_in = '{valid: 1'b1, op: CM_NEW, idx: tail.free_idx};
                  count_in  = count_ff + COUNT_BITS'(1);
               end else begin
                  status_in = STATUS_OVERFLOW;
               end
            end
            FUNC_GET: begin
               if (!tail.found) begin
                  status_in = STATUS_NOT_FOUND;
               end else if (CAP_BITS'(str_len(tail.found_value)) >= cap_ff) begin
                  status_in = STATUS_OVERFLOW;
               end else begin
                  read_value_in = tail.found_value;
               end
            end
            FUNC_DELETE: begin
               if (!tail.found) begin
                  status_in = STATUS_NOT_FOUND;
               end else begin
                  commit_in = '{valid: 1'b1, op: CM_CLEAR, idx: tail.found_idx};
                  if (count_ff != '0) begin
                     count_in = count_ff - COUNT_BITS'(1);
                  end
               end
            end
            default: begin
               status_in = STATUS_INVALID;
            end
         endcase
         entries_in = COUNT_OUT_BITS'(count_in);
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         closed_ff       <= 1'b0;
         count_ff        <= '0;
         launch_ff       <= 1'b0;
         commit_ff.valid <= 1'b0;
      end else begin
         state_ff  <= state_in;
         closed_ff <= closed_in;
         count_ff  <= count_in;
         launch_ff <= launch_in;
         commit_ff <= commit_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      func_ff       <= func_in;
      key_ff        <= key_in;
      value_ff      <= value_in;
      cap_ff        <= cap_in;
      status_ff     <= status_in;
      read_value_ff <= read_value_in;
      entries_ff    <= entries_in;
   end

   // Fresh search token at the head of the row
   always_comb begin
      token_chain[0]       = '0;
      token_chain[0].valid = launch_ff;
   end

   // Row of slot cells
   for (genvar g = 0; g < SLOT_COUNT; g++) begin : g_cell
      fskv_cell #(
         .KEY_BITS   (KEY_BITS),
         .VALUE_BITS (VALUE_BITS),
         .CELL_INDEX (g)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .key_word   (key_ff),
         .value_word (value_ff),
         .commit     (commit_ff),
         .up_token   (token_chain[g]),
         .down_token (token_chain[g+1])
      );
   end

   // Checks
   `FSKV_ASSERT(a_count_bound, count_ff <= COUNT_BITS'(SLOT_COUNT), "entry count above slot count")
   `FSKV_ASSERT(a_tail_in_scan, tail.valid |-> state_ff == ST_SCAN, "token left row outside scan")
   `FSKV_ASSERT(a_commit_pulse, commit_ff.valid |=> !commit_ff.valid, "slot update held over")
   `FSKV_ASSERT(a_closed_zero, closed_ff && rsp_ch.valid |-> entries_ff == '0, "count after close")
   `FSKV_ASSERT(a_no_accept_busy, rsp_ch.valid |-> !req_ch.ready, "request taken while result pending")

endmodule
